### src/hlsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlsp_pkg
// Shared types and constants of the hop-limited shortest path check unit.
// ----------------------------------------------------------------------------
package hlsp_pkg;

  localparam int VERTEX_COUNT_DEF = 32;
  localparam int EDGE_COUNT_DEF   = 64;

  localparam int VTX_BITS    = 5;
  localparam int SLOT_BITS   = 6;
  localparam int COST_BITS   = 8;
  localparam int WEIGHT_BITS = 8;
  localparam int DIST_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    OP_WRITE_EDGE  = 2'd0,
    OP_SET_ALIVE   = 2'd1,
    OP_CLEAR_ALIVE = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SOURCE = 2'd0,
    CFG_TARGET = 2'd1,
    CFG_LIMIT  = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SCAN_END,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_EDGE_UPD,
    ST_FIN_RD,
    ST_FIN_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [SLOT_BITS-1:0] edge_slot;
    logic [VTX_BITS-1:0]  end_a;
    logic [VTX_BITS-1:0]  end_b;
    logic [COST_BITS-1:0] edge_cost;
    logic                 alive_flag;
  } in_word_t;

  typedef struct packed {
    logic                 reachable;
    logic [DIST_BITS-1:0] path_distance;
  } out_word_t;

  // one edge entry as read back from the edge table
  typedef struct packed {
    logic                   alive;
    logic [VTX_BITS-1:0]    end_a;
    logic [VTX_BITS-1:0]    end_b;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_rd_t;

  // edge table update controls
  typedef struct packed {
    logic                   wr_en;
    logic                   alive_we;
    logic                   alive_val;
    logic                   alive_clr;
    logic [VTX_BITS-1:0]    end_a;
    logic [VTX_BITS-1:0]    end_b;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_wr_t;

endpackage

`default_nettype wire

### src/hop_limited_shortest_path_check_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hop_limited_shortest_path_check_unit
// Edge table with a Dijkstra search from a source vertex over alive edges.
// ----------------------------------------------------------------------------
// A query runs one round per vertex: a scan of the distance memory (a read
// and a compare per vertex, then a decision step) picks the closest pending
// vertex, then a relaxation pass reads every edge (edge read, distance read,
// write back per edge). A last scan finds no pending vertex, then the target
// distance is read and the result word formed. The result word is on out_data
// for exactly one cycle, marked by out_valid; the receiver cannot stall it.
// busy is high from the accepted query until the result word appears.
module hop_limited_shortest_path_check_unit
  import hlsp_pkg::*;
#(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int EDGE_COUNT   = EDGE_COUNT_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire in_word_t                in_data,
  output logic                         out_valid,
  output out_word_t                    out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [DIST_BITS-1:0]    cfg_data
);

  localparam int VW = $clog2(VERTEX_COUNT);
  localparam int EW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;

  // configuration
  logic [VTX_BITS-1:0]  src_r, tgt_r;
  logic [DIST_BITS-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r   <= '0;
      tgt_r   <= '0;
      limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SOURCE: src_r   <= cfg_data[VTX_BITS-1:0];
        CFG_TARGET: tgt_r   <= cfg_data[VTX_BITS-1:0];
        CFG_LIMIT:  limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic src_ok, tgt_ok;
  assign src_ok = 32'(src_r) < VERTEX_COUNT;
  assign tgt_ok = 32'(tgt_r) < VERTEX_COUNT;

  // control and datapath registers
  state_t                  state_r, state_nxt;
  logic [VW:0]             v_cnt_r, v_cnt_nxt;
  logic [EW:0]             e_cnt_r, e_cnt_nxt;
  logic                    have_r, have_nxt;
  logic [VW-1:0]           best_u_r, best_u_nxt;
  logic [DIST_BITS-1:0]    best_d_r, best_d_nxt;
  logic [VW-1:0]           to_r, to_nxt;
  logic [WEIGHT_BITS-1:0]  w_r, w_nxt;
  logic                    rel_ok_r, rel_ok_nxt;
  logic [VERTEX_COUNT-1:0] pend_r, pend_nxt;
  logic [VERTEX_COUNT-1:0] parent_r, parent_nxt;
  logic [VERTEX_COUNT-1:0] dvld_r, dvld_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r, out_data_nxt;

  // distance memory
  logic [DIST_BITS-1:0] dist_mem [VERTEX_COUNT];
  logic [DIST_BITS-1:0] dist_rd_r;
  logic                 dist_we;
  logic [VW-1:0]        dist_waddr, dist_raddr;
  logic [DIST_BITS-1:0] dist_wdata;
  logic                 dvld_rd_r;

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rd_r <= dist_mem[dist_raddr];
  end

  logic [DIST_BITS-1:0] dist_cur;
  assign dist_cur = dvld_rd_r ? dist_rd_r : DIST_MAX;

  // edge table
  edge_wr_t      edge_wr;
  logic [EW-1:0] edge_waddr, edge_raddr;
  edge_rd_t      edge_rd;

  hlsp_edge_tab #(
    .EDGE_COUNT (EDGE_COUNT),
    .EW         (EW)
  ) u_edge_tab (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (edge_wr),
    .wr_addr (edge_waddr),
    .rd_addr (edge_raddr),
    .rd_data (edge_rd)
  );

  logic accept, slot_ok;
  op_t  op;
  assign accept  = start && (state_r == ST_IDLE);
  assign op      = op_t'(in_data.operation);
  assign slot_ok = 32'(in_data.edge_slot) < EDGE_COUNT;
  assign busy    = state_r != ST_IDLE;

  // edge check helpers
  logic                ends_ok, hit_a, hit_b;
  logic [DIST_BITS:0]  sum_w;
  logic [DIST_BITS-1:0] nd;
  assign ends_ok = (32'(edge_rd.end_a) < VERTEX_COUNT) && (32'(edge_rd.end_b) < VERTEX_COUNT);
  assign hit_a   = 32'(edge_rd.end_a) == 32'(best_u_r);
  assign hit_b   = 32'(edge_rd.end_b) == 32'(best_u_r);
  assign sum_w   = {1'b0, best_d_r} + (DIST_BITS+1)'(w_r);
  assign nd      = sum_w[DIST_BITS] ? DIST_MAX : sum_w[DIST_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && op == OP_QUERY) begin
          state_nxt = src_ok ? ST_SCAN_RD : ST_FIN_RD;
        end
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        state_nxt = (32'(v_cnt_r) == VERTEX_COUNT - 1) ? ST_SCAN_END : ST_SCAN_RD;
      end
      ST_SCAN_END: begin
        priority if (!have_r) begin
          state_nxt = ST_FIN_RD;
        end else if (best_d_r == DIST_MAX) begin
          state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_EDGE_RD;
        end
      end
      ST_EDGE_RD:  state_nxt = ST_EDGE_CHK;
      ST_EDGE_CHK: state_nxt = ST_EDGE_UPD;
      ST_EDGE_UPD: begin
        state_nxt = (32'(e_cnt_r) == EDGE_COUNT - 1) ? ST_SCAN_RD : ST_EDGE_RD;
      end
      ST_FIN_RD:   state_nxt = ST_FIN_OUT;
      ST_FIN_OUT:  state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    v_cnt_nxt     = v_cnt_r;
    e_cnt_nxt     = e_cnt_r;
    have_nxt      = have_r;
    best_u_nxt    = best_u_r;
    best_d_nxt    = best_d_r;
    to_nxt        = to_r;
    w_nxt         = w_r;
    rel_ok_nxt    = rel_ok_r;
    pend_nxt      = pend_r;
    parent_nxt    = parent_r;
    dvld_nxt      = dvld_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    dist_we       = 1'b0;
    dist_waddr    = VW'(src_r);
    dist_wdata    = '0;
    dist_raddr    = v_cnt_r[VW-1:0];
    edge_wr       = '{wr_en: 1'b0, alive_we: 1'b0, alive_val: in_data.alive_flag,
                      alive_clr: 1'b0, end_a: in_data.end_a, end_b: in_data.end_b,
                      weight: WEIGHT_BITS'(in_data.edge_cost)};
    edge_waddr    = EW'(in_data.edge_slot);
    edge_raddr    = e_cnt_r[EW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_WRITE_EDGE:  edge_wr.wr_en     = slot_ok;
            OP_SET_ALIVE:   edge_wr.alive_we  = slot_ok;
            OP_CLEAR_ALIVE: edge_wr.alive_clr = 1'b1;
            OP_QUERY: begin
              pend_nxt   = '1;
              parent_nxt = '0;
              dvld_nxt   = '0;
              v_cnt_nxt  = '0;
              have_nxt   = 1'b0;
              if (src_ok) begin
                // source starts at distance zero
                dist_we              = 1'b1;
                dist_wdata           = '0;
                dvld_nxt[VW'(src_r)] = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: ;
      ST_SCAN_CMP: begin
        if (pend_r[v_cnt_r[VW-1:0]] && (!have_r || dist_cur < best_d_r)) begin
          have_nxt   = 1'b1;
          best_u_nxt = v_cnt_r[VW-1:0];
          best_d_nxt = dist_cur;
        end
        v_cnt_nxt = v_cnt_r + 1'b1;
      end
      ST_SCAN_END: begin
        e_cnt_nxt = '0;
        v_cnt_nxt = '0;
        if (have_r && best_d_r == DIST_MAX) begin
          pend_nxt[best_u_r] = 1'b0;
          have_nxt           = 1'b0;
        end
      end
      ST_EDGE_RD: ;
      ST_EDGE_CHK: begin
        to_nxt     = hit_a ? VW'(edge_rd.end_b) : VW'(edge_rd.end_a);
        w_nxt      = edge_rd.weight;
        rel_ok_nxt = edge_rd.alive && ends_ok && (hit_a || hit_b);
        dist_raddr = to_nxt;
      end
      ST_EDGE_UPD: begin
        dist_waddr = to_r;
        dist_wdata = nd;
        if (rel_ok_r && pend_r[to_r] && dist_cur > nd) begin
          dist_we          = 1'b1;
          dvld_nxt[to_r]   = 1'b1;
          parent_nxt[to_r] = 1'b1;
        end
        e_cnt_nxt = e_cnt_r + 1'b1;
        if (32'(e_cnt_r) == EDGE_COUNT - 1) begin
          pend_nxt[best_u_r] = 1'b0;
          have_nxt           = 1'b0;
          v_cnt_nxt          = '0;
        end
      end
      ST_FIN_RD: begin
        dist_raddr = VW'(tgt_r);
      end
      ST_FIN_OUT: begin
        out_valid_nxt = 1'b1;
        if (!tgt_ok) begin
          out_data_nxt = '{reachable: 1'b0, path_distance: DIST_MAX};
        end else begin
          out_data_nxt.path_distance = dist_cur;
          out_data_nxt.reachable     = (tgt_r != src_r) && parent_r[VW'(tgt_r)]
                                       && (dist_cur <= limit_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    dvld_rd_r <= dvld_r[dist_raddr];
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      pend_r      <= '1;
      parent_r    <= '0;
      dvld_r      <= '0;
      v_cnt_r     <= '0;
      e_cnt_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      pend_r      <= pend_nxt;
      parent_r    <= parent_nxt;
      dvld_r      <= dvld_nxt;
      v_cnt_r     <= v_cnt_nxt;
      e_cnt_r     <= e_cnt_nxt;
    end
    best_u_r   <= best_u_nxt;
    best_d_r   <= best_d_nxt;
    to_r       <= to_nxt;
    w_r        <= w_nxt;
    rel_ok_r   <= rel_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_FIN_OUT))
    else $error("result word without a finished query");
  a_reach_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.reachable) |-> (out_data_r.path_distance <= limit_r))
    else $error("reachable result beyond distance limit");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation == OP_QUERY) |=> busy)
    else $error("query accepted but unit not busy");
  a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EDGE_UPD) |-> pend_r[best_u_r])
    else $error("relaxing from a settled vertex");
`endif

endmodule

`default_nettype wire

### src/hlsp_edge_tab.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlsp_edge_tab
// Edge table: endpoint/weight memory with registered read, alive flags in
// flops so that a clear-all clears every flag at once.
// ----------------------------------------------------------------------------
module hlsp_edge_tab
  import hlsp_pkg::*;
#(
  parameter int EDGE_COUNT = EDGE_COUNT_DEF,
  parameter int EW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire edge_wr_t      wr,
  input  wire logic [EW-1:0] wr_addr,
  input  wire logic [EW-1:0] rd_addr,
  output edge_rd_t           rd_data
);

  typedef struct packed {
    logic [VTX_BITS-1:0]    end_a;
    logic [VTX_BITS-1:0]    end_b;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_ent_t;

  edge_ent_t             edge_mem [EDGE_COUNT];
  logic [EDGE_COUNT-1:0] alive_r;
  edge_ent_t             ent_r;
  logic                  alive_rd_r;

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      edge_mem[wr_addr] <= '{end_a: wr.end_a, end_b: wr.end_b, weight: wr.weight};
    end
    ent_r <= edge_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r    <= '0;
      alive_rd_r <= 1'b0;
    end else begin
      alive_rd_r <= alive_r[rd_addr];
      if (wr.alive_clr) begin
        alive_r <= '0;
      end else if (wr.alive_we) begin
        alive_r[wr_addr] <= wr.alive_val;
      end
    end
  end

  assign rd_data = '{alive: alive_rd_r, end_a: ent_r.end_a, end_b: ent_r.end_b,
                     weight: ent_r.weight};

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hop-limited shortest path check unit: edge
// table traffic and queries are mirrored by a Dijkstra predictor, and each
// query result word is compared against the oldest predicted result word.
// ----------------------------------------------------------------------------
module tb_top;
  import hlsp_pkg::*;

  localparam int NV = VERTEX_COUNT_DEF;
  localparam int NE = EDGE_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 60000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  in_word_t                in_data = '0;
  logic                    out_valid;
  out_word_t               out_data;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_NONE;
  logic [DIST_BITS-1:0]    cfg_data = '0;

  hop_limited_shortest_path_check_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the block
  logic [VTX_BITS-1:0]    src_vtx, dst_vtx;
  logic [DIST_BITS-1:0]   dist_limit;
  logic [VTX_BITS-1:0]    tbl_a [NE];
  logic [VTX_BITS-1:0]    tbl_b [NE];
  logic [WEIGHT_BITS-1:0] tbl_w [NE];
  logic                   tbl_alive [NE];

  in_word_t  pending_words[$];
  out_word_t expected_dist[$];
  bit        slot_written [NE];
  int        idle_pct = 0;
  int        mismatches = 0;
  int        wd_count = 0;

  function automatic out_word_t shortest_path(input logic [VTX_BITS-1:0] s,
                                              input logic [VTX_BITS-1:0] t);
    logic [DIST_BITS-1:0] dist_v [NV];
    bit   open_v [NV];
    bit   parent [NV];
    logic [DIST_BITS:0] sum;
    int   u, a, b, nb;
    out_word_t r;
    for (int v = 0; v < NV; v++) begin
      dist_v[v] = DIST_MAX; open_v[v] = 1; parent[v] = 0;
    end
    dist_v[s] = '0;
    for (int rnd = 0; rnd < NV; rnd++) begin
      u = -1;
      for (int v = 0; v < NV; v++)
        if (open_v[v] && (u < 0 || dist_v[v] < dist_v[u])) u = v;
      if (u < 0) break;
      if (dist_v[u] != DIST_MAX) begin
        for (int e = 0; e < NE; e++) begin
          if (!tbl_alive[e]) continue;
          a = tbl_a[e]; b = tbl_b[e];
          if (a == u) nb = b;
          else if (b == u) nb = a;
          else continue;
          if (!open_v[nb]) continue;
          sum = dist_v[u] + tbl_w[e];
          if (sum > DIST_MAX) sum = DIST_MAX;
          if (dist_v[nb] > sum[DIST_BITS-1:0]) begin
            dist_v[nb] = sum[DIST_BITS-1:0]; parent[nb] = 1;
          end
        end
      end
      open_v[u] = 0;
    end
    r.path_distance = dist_v[t];
    r.reachable = (t != s) && parent[t] && (dist_v[t] <= dist_limit);
    return r;
  endfunction

  function automatic void apply_word(input in_word_t w);
    case (op_t'(w.operation))
      OP_WRITE_EDGE: begin
        tbl_a[w.edge_slot] = w.end_a; tbl_b[w.edge_slot] = w.end_b;
        tbl_w[w.edge_slot] = w.edge_cost;
      end
      OP_SET_ALIVE: tbl_alive[w.edge_slot] = w.alive_flag;
      OP_CLEAR_ALIVE: for (int e = 0; e < NE; e++) tbl_alive[e] = 0;
      default: expected_dist.push_back(shortest_path(src_vtx, dst_vtx));
    endcase
  endfunction

  // endpoints mostly in a small cluster so that paths exist
  function automatic logic [VTX_BITS-1:0] pick_vtx();
    return ($urandom_range(0, 99) < 75) ? VTX_BITS'($urandom_range(0, 7))
                                        : VTX_BITS'($urandom());
  endfunction

  function automatic void queue_word(input op_t op, input int slot, input int a,
                                     input int b, input int cost, input bit flag);
    in_word_t w;
    w = in_word_t'($urandom());
    w.operation = op;
    w.edge_slot = SLOT_BITS'(slot);
    if (op == OP_WRITE_EDGE) begin
      w.end_a = VTX_BITS'(a); w.end_b = VTX_BITS'(b); w.edge_cost = COST_BITS'(cost);
      slot_written[slot] = 1;
    end
    if (op == OP_SET_ALIVE) w.alive_flag = flag;
    pending_words.push_back(w);
  endfunction

  function automatic void queue_random();
    int p, slot;
    p = $urandom_range(0, 99);
    slot = $urandom_range(0, NE - 1);
    if (p < 35)
      queue_word(OP_WRITE_EDGE, slot, pick_vtx(), pick_vtx(), $urandom_range(0, 255), 0);
    else if (p < 65) begin
      // never enable a slot that holds no edge yet
      if (slot_written[slot]) queue_word(OP_SET_ALIVE, slot, 0, 0, 0, $urandom_range(0, 3) != 0);
      else queue_word(OP_SET_ALIVE, slot, 0, 0, 0, 0);
    end else if (p < 68)
      queue_word(OP_CLEAR_ALIVE, slot, 0, 0, 0, 0);
    else
      queue_word(OP_QUERY, slot, 0, 0, 0, 0);
  endfunction

  // driver
  always @(posedge clk) begin
    bit       take_next;
    in_word_t nxt;
    take_next = 0;
    nxt = in_data;
    if (rst_n) begin
      if (start && !busy) apply_word(in_data);
      if ((!start || !busy) && pending_words.size() > 0 &&
          $urandom_range(0, 99) >= idle_pct) begin
        nxt = pending_words.pop_front();
        take_next = 1;
      end
      if (!start || !busy) start <= take_next;
      in_data <= nxt;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: reach=%0d dist=%0d",
                   out_data.reachable, out_data.path_distance);
      end else begin
        exp_w = expected_dist.pop_front();
        if (exp_w.reachable !== out_data.reachable ||
            exp_w.path_distance !== out_data.path_distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected reach=%0d dist=%0d, got reach=%0d dist=%0d",
                     exp_w.reachable, exp_w.path_distance,
                     out_data.reachable, out_data.path_distance);
        end
      end
    end
  end

  // watchdog: cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) wd_count <= 0;
    else wd_count <= wd_count + 1;
    if (wd_count >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [DIST_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      CFG_SOURCE: src_vtx = val[VTX_BITS-1:0];
      CFG_TARGET: dst_vtx = val[VTX_BITS-1:0];
      CFG_LIMIT:  dist_limit = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0; cfg_index <= CFG_NONE;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || start || busy || expected_dist.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_phase(input int pct, input int n, input int s, input int t,
                           input int lim);
    idle_pct = pct;
    cfg_write(CFG_SOURCE, DIST_BITS'(s));
    cfg_write(CFG_TARGET, DIST_BITS'(t));
    cfg_write(CFG_LIMIT, DIST_BITS'(lim));
    for (int i = 0; i < n; i++) queue_random();
    drain();
  endtask

  initial begin
    src_vtx = '0; dst_vtx = '0; dist_limit = '0;
    for (int e = 0; e < NE; e++) begin
      tbl_alive[e] = 0; slot_written[e] = 0;
      tbl_a[e] = '0; tbl_b[e] = '0; tbl_w[e] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: zero cost, max cost, self loop, alive handling, source==target
    cfg_write(CFG_SOURCE, 16'd0);
    cfg_write(CFG_TARGET, 16'd2);
    cfg_write(CFG_LIMIT, 16'hFFFF);
    queue_word(OP_QUERY, 0, 0, 0, 0, 0);
    queue_word(OP_WRITE_EDGE, 0, 0, 1, 0, 0);
    queue_word(OP_WRITE_EDGE, 63, 31, 30, 255, 0);
    queue_word(OP_WRITE_EDGE, 1, 2, 2, 5, 0);
    queue_word(OP_WRITE_EDGE, 2, 1, 2, 255, 0);
    queue_word(OP_WRITE_EDGE, 3, 31, 2, 1, 0);
    for (int s = 0; s < 4; s++) queue_word(OP_SET_ALIVE, s, 0, 0, 0, 1);
    queue_word(OP_SET_ALIVE, 63, 0, 0, 0, 1);
    queue_word(OP_SET_ALIVE, 40, 0, 0, 0, 0);
    queue_word(OP_QUERY, 5, 0, 0, 0, 0);
    queue_word(OP_SET_ALIVE, 2, 0, 0, 0, 0);
    queue_word(OP_QUERY, 0, 0, 0, 0, 0);
    queue_word(OP_SET_ALIVE, 2, 0, 0, 0, 1);
    queue_word(OP_CLEAR_ALIVE, 0, 0, 0, 0, 0);
    queue_word(OP_QUERY, 0, 0, 0, 0, 0);
    for (int s = 0; s < 4; s++) queue_word(OP_SET_ALIVE, s, 0, 0, 0, 1);
    queue_word(OP_SET_ALIVE, 63, 0, 0, 0, 1);
    drain();
    cfg_write(CFG_TARGET, 16'd31);
    cfg_write(CFG_LIMIT, 16'd0);
    queue_word(OP_QUERY, 0, 0, 0, 0, 0);
    drain();
    cfg_write(CFG_SOURCE, 16'd31);
    queue_word(OP_QUERY, 0, 0, 0, 0, 0);
    drain();

    // random phases across idle rates and register settings
    run_phase(0, 45, 0, 5, 'hFFFF);
    run_phase(66, 45, 31, 3, 300);
    run_phase(0, 35, 4, 4, 0);
    run_phase(22, 45, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 800));

    if (mismatches == 0 && expected_dist.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
